[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the chunker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted (active low).
`define CDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define CDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDC_ASSERT(lbl, clk, rstn, prop, msg)
`define CDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/cdc_pkg.sv]
// ----------------------------------------------------------------------------
// Chunker package
// Constants, types and the leave-term function shared by the chunker RTL.
// ----------------------------------------------------------------------------
package cdc_pkg;

    // Window geometry.
    localparam int WINDOW_SIZE = 48;
    localparam int POS_W       = $clog2(WINDOW_SIZE);

    // Field widths.
    localparam int LEN_W   = 24;
    localparam int MASK_W  = 32;
    localparam int HASH_W  = 64;
    localparam int CAUSE_W = 2;

    localparam logic [LEN_W-1:0]  LEN_LIMIT = {LEN_W{1'b1}};
    localparam logic [HASH_W-1:0] HASH_POLY = 64'hbfe6_b8a5_bf37_8d83;

    // Register reset values.
    localparam logic [LEN_W-1:0]  MIN_LEN_RST = 24'd4096;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 24'd65536;
    localparam logic [MASK_W-1:0] MASK_RST    = 32'd16383;

    // Register indexes (word address bits).
    localparam int              REG_IDX_W   = 2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LEN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MASK    = 2'd2;

    // Boundary cause codes.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_HASH = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_MAX  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_END  = 2'd3;

    // Control from the datapath to the window.
    typedef struct packed {
        logic       accept;
        logic       clear;
        logic [7:0] wr_byte;
    } win_ctrl_t;

    // Term removed from the hash for the byte that leaves the window:
    // eight reflected shift/XOR rounds against the fixed polynomial.
    function automatic logic [HASH_W-1:0] leave_term(input logic [7:0] v);
        logic [HASH_W-1:0] h;
        h = {{(HASH_W-8){1'b0}}, v};
        for (int k = 0; k < 8; k++) begin
            h = (h >> 1) ^ (HASH_POLY & {HASH_W{h[0]}});
        end
        return h;
    endfunction

endpackage

[rtl/cdc_window.sv]
// ----------------------------------------------------------------------------
// Chunker window
// Ring buffer of recent bytes with a write position and per-entry valid bits.
// The entry at the next position is prefetched so it is ready for the next
// word; an entry that has not been written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module cdc_window (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cdc_pkg::win_ctrl_t   ctrl,
    output logic [7:0]           old_byte
);

    localparam logic [cdc_pkg::POS_W-1:0] POS_LAST =
        cdc_pkg::POS_W'(cdc_pkg::WINDOW_SIZE - 1);

    logic [7:0]                      mem [cdc_pkg::WINDOW_SIZE];
    logic [7:0]                      rd_reg;
    logic [cdc_pkg::POS_W-1:0]       pos_reg;
    logic [cdc_pkg::POS_W-1:0]       pos_next;
    logic [cdc_pkg::WINDOW_SIZE-1:0] valid_reg;
    logic [cdc_pkg::WINDOW_SIZE-1:0] valid_next;

    // Position advances per word, wraps after the last entry and returns to zero on a boundary.
    always_comb begin
        pos_next = pos_reg;
        if (ctrl.accept) begin
            if (ctrl.clear || pos_reg == POS_LAST) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Valid bits stand in for clearing the window contents.
    always_comb begin
        valid_next = valid_reg;
        if (ctrl.accept) begin
            if (ctrl.clear) begin
                valid_next = '0;
            end else begin
                valid_next[pos_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            valid_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Window memory: write at the current position, read ahead at the next.
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            mem[pos_reg] <= ctrl.wr_byte;
        end
        rd_reg <= mem[pos_next];
    end

    assign old_byte = valid_reg[pos_reg] ? rd_reg : 8'd0;

endmodule

[rtl/content_defined_chunker_core.sv]
// ----------------------------------------------------------------------------
// Content-defined chunker core
// Rolling-hash chunk boundary detector, one byte per word.
//
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] data_byte, tlast stream_end
//  m_*       out        tdata[23:0] chunk_length, tdata[25:24] boundary_cause,
//                       tlast is_boundary
//  APB       in/out     0x0 min_chunk_len, 0x4 max_chunk_len, 0x8 boundary_mask
//
// One byte is accepted per cycle unless stalled; each byte produces one
// registered result word. The per-cycle limit is the hash update loop:
// leave-term lookup, shift, XOR and mask compare on the hash register.
// Reset is synchronous and active low; it clears the window, hash and length,
// and loads the register reset values. A stalled result holds and blocks
// input only while m_tready is low; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module content_defined_chunker_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // stream_end
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] chunk_length, [25:24] boundary_cause
    output logic        m_tlast,   // is_boundary
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                                accept;
    logic                                cfg_wr;
    logic [cdc_pkg::REG_IDX_W-1:0]       reg_idx;
    logic [cdc_pkg::LEN_W-1:0]           min_len_reg;
    logic [cdc_pkg::LEN_W-1:0]           max_len_reg;
    logic [cdc_pkg::MASK_W-1:0]          mask_reg;
    logic [cdc_pkg::HASH_W-1:0]          hash_reg;
    logic [cdc_pkg::HASH_W-1:0]          hash_mix;
    logic [cdc_pkg::HASH_W-1:0]          hash_new;
    logic [cdc_pkg::LEN_W-1:0]           len_reg;
    logic [cdc_pkg::LEN_W-1:0]           len_new;
    logic [cdc_pkg::CAUSE_W-1:0]         cause;
    logic [7:0]                          old_byte;
    cdc_pkg::win_ctrl_t                  win_ctrl;
    logic                                m_valid_reg;
    logic                                m_last_reg;
    logic [cdc_pkg::LEN_W-1:0]           m_len_reg;
    logic [cdc_pkg::CAUSE_W-1:0]         m_cause_reg;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= cdc_pkg::MIN_LEN_RST;
            max_len_reg <= cdc_pkg::MAX_LEN_RST;
            mask_reg    <= cdc_pkg::MASK_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                cdc_pkg::REG_MIN_LEN: min_len_reg <= pwdata[cdc_pkg::LEN_W-1:0];
                cdc_pkg::REG_MAX_LEN: max_len_reg <= pwdata[cdc_pkg::LEN_W-1:0];
                cdc_pkg::REG_MASK:    mask_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cdc_pkg::REG_MIN_LEN: prdata = {8'd0, min_len_reg};
            cdc_pkg::REG_MAX_LEN: prdata = {8'd0, max_len_reg};
            cdc_pkg::REG_MASK:    prdata = mask_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // Input handshake: a new word enters whenever the result slot frees up.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Hash update: remove the leaving byte, shift, and mix in the new byte.
    assign hash_mix = hash_reg ^ cdc_pkg::leave_term(old_byte);
    assign hash_new = {hash_mix[cdc_pkg::HASH_W-2:0], 1'b0}
                    ^ {{(cdc_pkg::HASH_W-8){1'b0}}, s_tdata};

    // Saturating length count.
    assign len_new = (len_reg == cdc_pkg::LEN_LIMIT) ? len_reg : len_reg + 1'b1;

    // Boundary decision: maximum before hash match, end of stream last.
    always_comb begin
        cause = cdc_pkg::CAUSE_NONE;
        if (len_new >= min_len_reg) begin
            if (len_new >= max_len_reg) begin
                cause = cdc_pkg::CAUSE_MAX;
            end else if ((hash_new[cdc_pkg::MASK_W-1:0] & mask_reg) == '0) begin
                cause = cdc_pkg::CAUSE_HASH;
            end
        end
        if (cause == cdc_pkg::CAUSE_NONE && s_tlast) begin
            cause = cdc_pkg::CAUSE_END;
        end
    end

    // Window of recent bytes.
    assign win_ctrl.accept  = accept;
    assign win_ctrl.clear   = (cause != cdc_pkg::CAUSE_NONE);
    assign win_ctrl.wr_byte = s_tdata;

    cdc_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (win_ctrl),
        .old_byte (old_byte)
    );

    // Hash and length state; a boundary clears both.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            len_reg  <= '0;
        end else if (accept) begin
            if (win_ctrl.clear) begin
                hash_reg <= '0;
                len_reg  <= '0;
            end else begin
                hash_reg <= hash_new;
                len_reg  <= len_new;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_last_reg  <= win_ctrl.clear;
            m_len_reg   <= win_ctrl.clear ? len_new : '0;
            m_cause_reg <= cause;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_cause_reg, m_len_reg};

    // Checks on the result contents and state clearing.
    `CDC_ASSERT(a_bound_len, aclk, aresetn, m_valid_reg && m_last_reg |-> m_len_reg != '0, "boundary with zero length")
    `CDC_ASSERT(a_bound_cause, aclk, aresetn, m_valid_reg |-> (m_last_reg == (m_cause_reg != cdc_pkg::CAUSE_NONE)), "boundary flag and cause disagree")
    `CDC_ASSERT(a_plain_zero, aclk, aresetn, m_valid_reg && !m_last_reg |-> m_len_reg == '0, "non-boundary result carries a length")
    `CDC_ASSERT(a_clear_state, aclk, aresetn, accept && win_ctrl.clear |=> len_reg == '0 && hash_reg == '0, "state not cleared after boundary")

endmodule
